### rtl/lfcd_pkg.sv
// shared types, constants and the crc-16/x.25 byte update for the deframer
// no dependencies
package lfcd_pkg;

    localparam logic [7:0]  START_HI       = 8'h02;
    localparam logic [7:0]  START_LO       = 8'h03;
    localparam logic [7:0]  END_BYTE       = 8'h03;
    localparam logic [15:0] CRC_POLY       = 16'h8408;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_XOROUT     = 16'hFFFF;
    localparam logic [8:0]  AUTH_INDEX     = 9'd5;
    // frame of length + 3 bytes: too short below 8 bytes, auth needs more than 6
    localparam logic [7:0]  MIN_LEN        = 8'd5;
    localparam logic [7:0]  AUTH_MIN_LEN   = 8'd3;
    localparam logic [8:0]  FRAME_TAIL     = 9'd2;

    localparam logic [2:0]  ST_OK          = 3'd0;
    localparam logic [2:0]  ST_TOO_SHORT   = 3'd1;
    localparam logic [2:0]  ST_BAD_START   = 3'd2;
    localparam logic [2:0]  ST_BAD_END     = 3'd3;
    localparam logic [2:0]  ST_BAD_CRC     = 3'd4;

    typedef struct packed {
        logic [7:0] byte_out;
        logic [8:0] byte_index;
        logic       frame_last;
        logic [2:0] frame_status;
        logic       auth_ok;
    } t_result;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### rtl/length_framed_crc_deframer_core.sv
// Deframer for STX/length/ETX frames checked with CRC-16/X.25. One received byte is
// taken per request and each byte is presented as one result, through the input
// register and the result register, with its index in the frame; the last byte of a
// frame (index length + 2) also carries the status and auth flag. A new byte can be
// taken every cycle unless a stalled result is held: the byte-wide crc update and the
// position compare sit between the input register and the result register.
// top level, uses lfcd_pkg, lfcd_in_reg and lfcd_frame
module length_framed_crc_deframer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_byte_out,
    output logic [8:0] o_byte_index,
    output logic       o_frame_last,
    output logic [2:0] o_frame_status,
    output logic       o_auth_ok
);

    logic              in_valid;
    logic [7:0]        in_byte;
    logic              take;
    lfcd_pkg::t_result result;

    lfcd_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_rx_byte (i_rx_byte),
        .o_stall   (o_stall),
        .i_take    (take),
        .o_valid   (in_valid),
        .o_byte    (in_byte)
    );

    lfcd_frame u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (in_valid),
        .i_byte   (in_byte),
        .i_stall  (i_stall),
        .o_take   (take),
        .o_valid  (o_valid),
        .o_result (result)
    );

    assign o_byte_out     = result.byte_out;
    assign o_byte_index   = result.byte_index;
    assign o_frame_last   = result.frame_last;
    assign o_frame_status = result.frame_status;
    assign o_auth_ok      = result.auth_ok;

endmodule

### rtl/lfcd_in_reg.sv
// input register stage of the deframer, holds one received byte
// depends on nothing but the clock and the downstream take signal
module lfcd_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_rx_byte,
    output logic       o_stall,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       load_ok;

    assign load_ok = !r_valid || i_take;
    assign o_stall = !load_ok;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load_ok) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_ok && i_valid) begin
            r_byte <= i_rx_byte;
        end
    end

endmodule

### rtl/lfcd_frame.sv
// frame tracking, crc check and result register of the deframer
// uses lfcd_pkg for constants, the crc update and the result struct
module lfcd_frame (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_byte,
    input  logic               i_stall,
    output logic               o_take,
    output logic               o_valid,
    output lfcd_pkg::t_result  o_result
);

    logic [8:0]  r_position, n_position;
    logic [7:0]  r_frame_length, n_frame_length;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_rx_crc, n_rx_crc;
    logic        r_start_ok, n_start_ok;
    logic        r_auth_byte, n_auth_byte;
    logic        r_out_valid;
    lfcd_pkg::t_result r_result, n_result;

    logic [15:0] crc_upd;
    logic [9:0]  pos_plus1;
    logic        last;

    assign o_take   = i_valid && (!r_out_valid || !i_stall);
    assign o_valid  = r_out_valid;
    assign o_result = r_result;

    assign crc_upd   = lfcd_pkg::crc_byte(r_crc, i_byte);
    assign pos_plus1 = {1'b0, r_position} + 10'd1;

    always_comb begin
        n_position     = r_position;
        n_frame_length = r_frame_length;
        n_crc          = r_crc;
        n_rx_crc       = r_rx_crc;
        n_start_ok     = r_start_ok;
        n_auth_byte    = r_auth_byte;

        if (r_position == 9'd0) begin
            n_start_ok     = (i_byte == lfcd_pkg::START_HI);
            n_crc          = lfcd_pkg::CRC_INIT;
            n_rx_crc       = 16'h0000;
            n_auth_byte    = 1'b0;
            n_frame_length = 8'd0;
        end else if (r_position == 9'd1) begin
            n_start_ok = r_start_ok && (i_byte == lfcd_pkg::START_LO);
            n_crc      = crc_upd;
        end else if (r_position == 9'd2) begin
            n_frame_length = i_byte;
            n_crc          = crc_upd;
        end else begin
            if (pos_plus1 <= {2'b00, r_frame_length}) begin
                n_crc = crc_upd;
            end else if (r_position == {1'b0, r_frame_length}) begin
                n_rx_crc = {i_byte, 8'h00};
            end else if (r_position == {1'b0, r_frame_length} + 9'd1) begin
                n_rx_crc = {r_rx_crc[15:8], i_byte};
            end
        end
        if (r_position == lfcd_pkg::AUTH_INDEX) begin
            n_auth_byte = (i_byte == 8'd1);
        end

        last = (r_position >= 9'd2)
            && (r_position == {1'b0, n_frame_length} + lfcd_pkg::FRAME_TAIL);

        n_result.byte_out     = i_byte;
        n_result.byte_index   = r_position;
        n_result.frame_last   = last;
        n_result.frame_status = lfcd_pkg::ST_OK;
        n_result.auth_ok      = 1'b0;

        if (last) begin
            if (n_frame_length < lfcd_pkg::MIN_LEN) begin
                n_result.frame_status = lfcd_pkg::ST_TOO_SHORT;
            end else if (!n_start_ok) begin
                n_result.frame_status = lfcd_pkg::ST_BAD_START;
            end else if (i_byte != lfcd_pkg::END_BYTE) begin
                n_result.frame_status = lfcd_pkg::ST_BAD_END;
            end else if ((n_crc ^ lfcd_pkg::CRC_XOROUT) != n_rx_crc) begin
                n_result.frame_status = lfcd_pkg::ST_BAD_CRC;
            end
            n_result.auth_ok = (n_frame_length > lfcd_pkg::AUTH_MIN_LEN) && n_auth_byte;
            n_position       = 9'd0;
        end else begin
            n_position = pos_plus1[8:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position     <= 9'd0;
            r_frame_length <= 8'd0;
            r_crc          <= lfcd_pkg::CRC_INIT;
            r_rx_crc       <= 16'h0000;
            r_start_ok     <= 1'b0;
            r_auth_byte    <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (o_take) begin
                r_position     <= n_position;
                r_frame_length <= n_frame_length;
                r_crc          <= n_crc;
                r_rx_crc       <= n_rx_crc;
                r_start_ok     <= n_start_ok;
                r_auth_byte    <= n_auth_byte;
                r_out_valid    <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_result <= n_result;
        end
    end

endmodule

### rtl/lfcd_checker.sv
// port-level checks for the deframer top level, with its bind
// depends on lfcd_pkg and length_framed_crc_deframer_core
module lfcd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_byte_out,
    input logic [8:0] o_byte_index,
    input logic       o_frame_last,
    input logic [2:0] o_frame_status,
    input logic       o_auth_ok
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_byte_out) && $stable(o_byte_index)
            && $stable(o_frame_last) && $stable(o_frame_status) && $stable(o_auth_ok))
        else $error("stalled result changed");

    a_mid_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_frame_last |-> o_frame_status == lfcd_pkg::ST_OK && !o_auth_ok)
        else $error("status or auth set on a byte that is not last");

    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_frame_last |=>
            !o_valid || o_byte_index == $past(o_byte_index) + 9'd1)
        else $error("byte index did not advance by one");

    a_index_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_frame_last |=> !o_valid || o_byte_index == 9'd0)
        else $error("frame after last byte did not restart at index zero");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_last |-> o_byte_index >= 9'd2)
        else $error("frame ended before the length byte");

endmodule

bind length_framed_crc_deframer_core lfcd_checker u_lfcd_checker (.*);

### bench/testbench.sv
// testbench for length_framed_crc_deframer_core: framed byte streams in, echoed bytes out,
// with status and auth flag checked against a scoreboard that tracks the frame state.
// depends on rtl/lfcd_pkg.sv and the deframer rtl
module testbench;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 16;
    localparam int ITEM_TARGET    = 950;

    class deframer_scoreboard;
        localparam int FRAME_MIN_BYTES = 8;
        localparam int FRAME_EXTRA     = 3;
        localparam int AUTH_MIN_BYTES  = 6;

        logic [8:0]        position;
        logic [7:0]        frame_len;
        logic [15:0]       crc;
        logic [15:0]       rx_crc;
        bit                start_good;
        bit                auth_byte_one;
        lfcd_pkg::t_result expected_q[$];
        int                mismatches;
        int                bytes_seen;
        int                auth_count;
        int                status_count[5];

        function new();
            position      = '0;
            frame_len     = '0;
            crc           = lfcd_pkg::CRC_INIT;
            rx_crc        = '0;
            start_good    = 1'b0;
            auth_byte_one = 1'b0;
            mismatches    = 0;
            bytes_seen    = 0;
            auth_count    = 0;
            foreach (status_count[i]) status_count[i] = 0;
        endfunction

        static function logic [15:0] crc_x25(input logic [15:0] crc_in, input logic [7:0] b);
            logic [15:0] c;
            logic        fb;
            c = crc_in;
            for (int i = 0; i < 8; i++) begin
                fb = c[0] ^ b[i];
                c = {1'b0, c[15:1]};
                if (fb) begin
                    c = c ^ lfcd_pkg::CRC_POLY;
                end
            end
            return c;
        endfunction

        // accepted request: advance the frame state and queue the echo
        function void note(input logic [7:0] b);
            int                p;
            int                len;
            int                total;
            bit                last;
            lfcd_pkg::t_result r;
            p = int'(position);
            if (p == 0) begin
                start_good    = (b == lfcd_pkg::START_HI);
                crc           = lfcd_pkg::CRC_INIT;
                rx_crc        = '0;
                auth_byte_one = 1'b0;
                frame_len     = '0;
            end else if (p == 1) begin
                start_good = start_good && (b == lfcd_pkg::START_LO);
                crc        = crc_x25(crc, b);
            end else if (p == 2) begin
                frame_len = b;
                crc       = crc_x25(crc, b);
            end else begin
                len = int'(frame_len);
                if (p + 1 <= len) begin
                    crc = crc_x25(crc, b);
                end else if (p == len) begin
                    rx_crc = {b, 8'h00};
                end else if (p == len + 1) begin
                    rx_crc = {rx_crc[15:8], b};
                end
            end
            if (p == int'(lfcd_pkg::AUTH_INDEX)) begin
                auth_byte_one = (b == 8'd1);
            end
            len  = int'(frame_len);
            last = (p >= 2) && (p == len + 2);
            r = '0;
            r.byte_out   = b;
            r.byte_index = p[8:0];
            r.frame_last = last;
            if (last) begin
                total = len + FRAME_EXTRA;
                if (total < FRAME_MIN_BYTES) begin
                    r.frame_status = lfcd_pkg::ST_TOO_SHORT;
                end else if (!start_good) begin
                    r.frame_status = lfcd_pkg::ST_BAD_START;
                end else if (b != lfcd_pkg::END_BYTE) begin
                    r.frame_status = lfcd_pkg::ST_BAD_END;
                end else if ((crc ^ lfcd_pkg::CRC_XOROUT) != rx_crc) begin
                    r.frame_status = lfcd_pkg::ST_BAD_CRC;
                end else begin
                    r.frame_status = lfcd_pkg::ST_OK;
                end
                r.auth_ok = (total > AUTH_MIN_BYTES) && auth_byte_one;
                status_count[r.frame_status]++;
                if (r.auth_ok) begin
                    auth_count++;
                end
                position = '0;
            end else begin
                position = 9'(p + 1);
            end
            expected_q.push_back(r);
            bytes_seen++;
        endfunction

        function void check(input lfcd_pkg::t_result got);
            lfcd_pkg::t_result want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected echo: data %h idx %0d last %b status %0d auth %b",
                             got.byte_out, got.byte_index, got.frame_last,
                             got.frame_status, got.auth_ok);
                end
                return;
            end
            want = expected_q.pop_front();
            if (got.byte_out !== want.byte_out || got.byte_index !== want.byte_index ||
                got.frame_last !== want.frame_last || got.frame_status !== want.frame_status ||
                got.auth_ok !== want.auth_ok) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: expected data %h idx %0d last %b status %0d auth %b",
                             want.byte_out, want.byte_index, want.frame_last,
                             want.frame_status, want.auth_ok);
                    $display("          actual   data %h idx %0d last %b status %0d auth %b",
                             got.byte_out, got.byte_index, got.frame_last,
                             got.frame_status, got.auth_ok);
                end
            end
        endfunction
    endclass

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_valid    = 1'b0;
    logic [7:0] i_rx_byte  = 8'h00;
    logic       i_stall    = 1'b1;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_byte_out;
    logic [8:0] o_byte_index;
    logic       o_frame_last;
    logic [2:0] o_frame_status;
    logic       o_auth_ok;

    deframer_scoreboard sb;
    lfcd_pkg::t_result  echo;
    bit                 calm = 1'b0;
    int                 quiet_cycles = 0;
    int                 frame_no;
    int                 len_pick;
    int                 len;
    int                 kind;
    bit                 bs;
    bit                 be;
    bit                 bc;

    length_framed_crc_deframer_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_byte_out     (o_byte_out),
        .o_byte_index   (o_byte_index),
        .o_frame_last   (o_frame_last),
        .o_frame_status (o_frame_status),
        .o_auth_ok      (o_auth_ok)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 22);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            echo.byte_out     = o_byte_out;
            echo.byte_index   = o_byte_index;
            echo.frame_last   = o_frame_last;
            echo.frame_status = o_frame_status;
            echo.auth_ok      = o_auth_ok;
            sb.check(echo);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (!calm && $urandom_range(0, 99) < 22) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        sb.note(b);
    endtask

    task automatic drain_echoes();
        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    // build a frame of len + 3 bytes, well formed unless a fault is asked for
    task automatic send_frame(input int flen, input bit bad_start, input bit bad_end,
                              input bit bad_crc, input bit want_auth);
        logic [7:0]  fr[$];
        logic [15:0] c;
        int          n;
        n = flen + 3;
        for (int i = 0; i < n; i++) fr.push_back(8'($urandom_range(0, 255)));
        fr[0] = lfcd_pkg::START_HI;
        fr[1] = lfcd_pkg::START_LO;
        fr[2] = 8'(flen);
        if (bad_start) begin
            if ($urandom_range(0, 1)) begin
                fr[0] = fr[0] ^ 8'($urandom_range(1, 255));
            end else begin
                fr[1] = fr[1] ^ 8'($urandom_range(1, 255));
            end
        end
        if (want_auth && n > 6) begin
            fr[lfcd_pkg::AUTH_INDEX] = 8'd1;
        end
        if (flen >= 5) begin
            c = lfcd_pkg::CRC_INIT;
            for (int i = 1; i < flen; i++) c = deframer_scoreboard::crc_x25(c, fr[i]);
            c = c ^ lfcd_pkg::CRC_XOROUT;
            fr[flen]     = c[15:8];
            fr[flen + 1] = c[7:0];
            if (bad_crc) begin
                fr[flen + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
            end
        end
        if (flen >= 1) begin
            fr[n - 1] = lfcd_pkg::END_BYTE;
            if (bad_end) begin
                fr[n - 1] = fr[n - 1] ^ 8'($urandom_range(1, 255));
            end
        end
        foreach (fr[i]) send_byte(fr[i]);
    endtask

    // random bytes out of step with any frame, then filler until a frame boundary
    task automatic send_noise();
        logic [7:0] b;
        int         n;
        n = $urandom_range(1, 12);
        for (int i = 0; i < n || sb.position != 0; i++) begin
            b = 8'($urandom_range(0, 255));
            if (sb.position == 9'd2 && $urandom_range(0, 3) != 0) begin
                b = 8'($urandom_range(0, 24));
            end
            send_byte(b);
        end
    endtask

    initial begin
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: good frame with auth, shortest frame, short frame with auth, all faults
        send_frame(6, 1'b0, 1'b0, 1'b0, 1'b1);
        send_frame(0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_frame(4, 1'b0, 1'b0, 1'b0, 1'b1);
        send_frame(5, 1'b1, 1'b1, 1'b1, 1'b0);

        frame_no = 0;
        while (sb.bytes_seen < ITEM_TARGET) begin
            frame_no++;
            if (frame_no == 12) begin
                drain_echoes();
            end
            calm = (frame_no >= 18 && frame_no < 28);
            len_pick = $urandom_range(0, 99);
            if (frame_no == 6) begin
                len = 255;
            end else if (len_pick < 75) begin
                len = $urandom_range(5, 20);
            end else if (len_pick < 85) begin
                len = $urandom_range(0, 4);
            end else begin
                len = $urandom_range(21, 120);
            end
            kind = $urandom_range(0, 99);
            if (kind < 8) begin
                send_noise();
            end else if (kind < 60) begin
                send_frame(len, 1'b0, 1'b0, 1'b0, $urandom_range(0, 1));
            end else begin
                do begin
                    bs = $urandom_range(0, 1);
                    be = $urandom_range(0, 1);
                    bc = $urandom_range(0, 1);
                end while (!(bs || be || bc));
                send_frame(len, bs, be, bc, $urandom_range(0, 1));
            end
        end
        calm = 1'b0;

        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d bytes; frames closed: %0d ok, %0d too short, %0d bad start,",
                 sb.bytes_seen, sb.status_count[lfcd_pkg::ST_OK],
                 sb.status_count[lfcd_pkg::ST_TOO_SHORT],
                 sb.status_count[lfcd_pkg::ST_BAD_START]);
        $display("%0d bad end, %0d bad crc; auth flag set on %0d frames, %0d mismatches",
                 sb.status_count[lfcd_pkg::ST_BAD_END], sb.status_count[lfcd_pkg::ST_BAD_CRC],
                 sb.auth_count, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/lfcd_pkg.sv
rtl/lfcd_in_reg.sv
rtl/lfcd_frame.sv
rtl/length_framed_crc_deframer_core.sv
rtl/lfcd_checker.sv
bench/testbench.sv
